>>> hw/rtl/dfhe_pkg.sv
// shared types, constants and helpers of the fixed-huffman deflate token encoder
`default_nettype none

package dfhe_pkg;

  // token kinds
  localparam logic FUNC_LITERAL = 1'b0;
  localparam logic FUNC_MATCH   = 1'b1;

  // literal code split and offsets
  localparam int unsigned LIT_SPLIT   = 143;
  localparam int unsigned LIT_OFS_LO  = 48;
  localparam int unsigned LIT_OFS_HI  = 256;
  localparam int unsigned LIT_WIDTH_LO = 8;
  localparam int unsigned LIT_WIDTH_HI = 9;

  // length symbols
  localparam int unsigned LEN_MIN       = 3;
  localparam int unsigned LEN_MAX       = 258;
  localparam int unsigned LEN_MAX_IDX   = 28;
  localparam int unsigned SYM_BASE      = 257;
  localparam int unsigned SYM_SHORT_MAX = 279;
  localparam int unsigned SYM_SHORT_OFS = 256;
  localparam int unsigned SYM_LONG_OFS  = 88;
  localparam int unsigned SYM_WIDTH_SHORT = 7;
  localparam int unsigned SYM_WIDTH_LONG  = 8;

  // distance codes
  localparam int unsigned DIST_MIN   = 1;
  localparam int unsigned DIST_MAX   = 32768;
  localparam int unsigned DIST_CODE_WIDTH = 5;

  // one input item
  typedef struct packed {
    logic        func;
    logic [7:0]  literal_byte;
    logic [8:0]  match_length;
    logic [15:0] match_distance;
  } in_t;

  // one result item
  typedef struct packed {
    logic [8:0]  sym_code;
    logic [3:0]  sym_width;
    logic [4:0]  len_extra;
    logic [2:0]  len_extra_width;
    logic        has_distance;
    logic [4:0]  dist_code;
    logic [12:0] dist_extra;
    logic [3:0]  dist_extra_width;
    logic [4:0]  total_bits;
    logic        bad_token;
  } out_t;

  // length coder result
  typedef struct packed {
    logic [4:0] idx;
    logic [4:0] extra;
    logic [2:0] width;
  } len_code_t;

  // distance coder result
  typedef struct packed {
    logic [4:0]  code;
    logic [12:0] extra;
    logic [3:0]  width;
  } dist_code_t;

  // position of the highest set bit, zero for a zero word
  function automatic logic [3:0] msb_pos(input logic [14:0] v);
    logic [3:0] pos;
    pos = 4'd0;
    for (int i = 0; i < 15; i++) begin
      if (v[i]) begin
        pos = 4'(i);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dfhe_len_coder.sv
// match length to length symbol index and extra bits
`default_nettype none

module dfhe_len_coder (
  input  wire logic [8:0]         match_length,
  output dfhe_pkg::len_code_t     code
);

  logic [8:0] ofs;
  logic [7:0] l;
  logic [3:0] p;
  logic [2:0] nbits;
  logic [7:0] shifted;
  logic [7:0] mask;

  // offset from the shortest length, msb picks the group
  assign ofs     = match_length - 9'(dfhe_pkg::LEN_MIN);
  assign l       = ofs[7:0];
  assign p       = dfhe_pkg::msb_pos({7'd0, l});
  assign nbits   = 3'(p - 4'd2);
  assign shifted = l >> nbits;
  assign mask    = (8'd1 << nbits) - 8'd1;

  // short lengths map one to one, the longest length has its own symbol
  always_comb begin
    if (match_length == 9'(dfhe_pkg::LEN_MAX)) begin
      code.idx   = 5'(dfhe_pkg::LEN_MAX_IDX);
      code.extra = 5'd0;
      code.width = 3'd0;
    end else if (l < 8'd8) begin
      code.idx   = l[4:0];
      code.extra = 5'd0;
      code.width = 3'd0;
    end else begin
      code.idx   = {3'(p - 4'd1), shifted[1:0]};
      code.extra = 5'(l & mask);
      code.width = nbits;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/dfhe_dist_coder.sv
// match distance to five-bit distance code and extra bits
`default_nettype none

module dfhe_dist_coder (
  input  wire logic [15:0]        match_distance,
  output dfhe_pkg::dist_code_t    code
);

  logic [15:0] ofs;
  logic [14:0] d;
  logic [3:0]  p;
  logic [3:0]  nbits;
  logic [14:0] shifted;
  logic [14:0] mask;

  // offset from the shortest distance, msb picks the code pair
  assign ofs     = match_distance - 16'(dfhe_pkg::DIST_MIN);
  assign d       = ofs[14:0];
  assign p       = dfhe_pkg::msb_pos(d);
  assign nbits   = p - 4'd1;
  assign shifted = d >> nbits;
  assign mask    = (15'd1 << nbits) - 15'd1;

  // first four distances carry no extra bits
  always_comb begin
    if (d < 15'd4) begin
      code.code  = {3'd0, d[1:0]};
      code.extra = 13'd0;
      code.width = 4'd0;
    end else begin
      code.code  = {p, shifted[0]};
      code.extra = 13'(d & mask);
      code.width = nbits;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/deflate_fixed_huffman_symbol_encoder.sv
// top level of the fixed-huffman deflate token encoder
//
// One LZ77 token enters per item on the in_ channel (valid/ready) and one
// result item leaves on the out_ channel (valid/ready). A token is either a
// literal byte or a match (length 3..258, distance 1..32768); the result
// holds the fixed literal/length code and width, length extra bits, distance
// code and extra bits, and the total bit count. A match whose length or
// distance is out of range gives bad_token set and every other field zero.
// The token is captured in an input register at acceptance, coded by short
// logic and captured in the result register once that register is empty or
// being emptied; out_valid then rises and the receiver can take the item.
// Throughput is one item per cycle while out_ready stays high; in_ready
// stays high while the result register is empty or being emptied in that
// cycle, so with out_ready held high a new token may enter on every clock.
// When the receiver stalls, the result register holds its item and the input
// register still takes one more token; after that in_ready drops until the
// receiver takes an item. Synchronous reset empties both registers; no
// configuration and no state beyond the two pipeline registers.
`default_nettype none

module deflate_fixed_huffman_symbol_encoder (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire dfhe_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output dfhe_pkg::out_t     out_data
);

  dfhe_pkg::in_t        tok_r;
  logic                 tok_vld_r, tok_vld_nxt;
  dfhe_pkg::out_t       res_r, res_nxt;
  logic                 res_vld_r, res_vld_nxt;
  logic                 in_fire, adv;
  dfhe_pkg::len_code_t  lcode;
  dfhe_pkg::dist_code_t dcode;
  logic                 bad;
  logic [8:0]           sym;

  // handshake between the two registers
  assign adv      = tok_vld_r && (!res_vld_r || out_ready);
  assign in_ready = !tok_vld_r || adv;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    tok_vld_nxt = tok_vld_r;
    if (in_fire) begin
      tok_vld_nxt = 1'b1;
    end else if (adv) begin
      tok_vld_nxt = 1'b0;
    end
    res_vld_nxt = res_vld_r;
    if (adv) begin
      res_vld_nxt = 1'b1;
    end else if (out_ready) begin
      res_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_vld_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  // input token register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      tok_r <= in_data;
    end
  end

  dfhe_len_coder u_len (
    .match_length (tok_r.match_length),
    .code         (lcode)
  );

  dfhe_dist_coder u_dist (
    .match_distance (tok_r.match_distance),
    .code           (dcode)
  );

  // range check on matches
  assign bad = (tok_r.match_length < 9'(dfhe_pkg::LEN_MIN))
            || (tok_r.match_length > 9'(dfhe_pkg::LEN_MAX))
            || (tok_r.match_distance < 16'(dfhe_pkg::DIST_MIN))
            || (tok_r.match_distance > 16'(dfhe_pkg::DIST_MAX));

  assign sym = 9'(dfhe_pkg::SYM_BASE) + {4'd0, lcode.idx};

  // assemble the result item
  always_comb begin
    res_nxt = '0;
    if (tok_r.func == dfhe_pkg::FUNC_LITERAL) begin
      if (tok_r.literal_byte <= 8'(dfhe_pkg::LIT_SPLIT)) begin
        res_nxt.sym_code  = {1'b0, tok_r.literal_byte} + 9'(dfhe_pkg::LIT_OFS_LO);
        res_nxt.sym_width = 4'(dfhe_pkg::LIT_WIDTH_LO);
      end else begin
        res_nxt.sym_code  = {1'b0, tok_r.literal_byte} + 9'(dfhe_pkg::LIT_OFS_HI);
        res_nxt.sym_width = 4'(dfhe_pkg::LIT_WIDTH_HI);
      end
      res_nxt.total_bits = 5'(res_nxt.sym_width);
    end else if (bad) begin
      res_nxt.bad_token = 1'b1;
    end else begin
      if (sym <= 9'(dfhe_pkg::SYM_SHORT_MAX)) begin
        res_nxt.sym_code  = sym - 9'(dfhe_pkg::SYM_SHORT_OFS);
        res_nxt.sym_width = 4'(dfhe_pkg::SYM_WIDTH_SHORT);
      end else begin
        res_nxt.sym_code  = sym - 9'(dfhe_pkg::SYM_LONG_OFS);
        res_nxt.sym_width = 4'(dfhe_pkg::SYM_WIDTH_LONG);
      end
      res_nxt.len_extra        = lcode.extra;
      res_nxt.len_extra_width  = lcode.width;
      res_nxt.has_distance     = 1'b1;
      res_nxt.dist_code        = dcode.code;
      res_nxt.dist_extra       = dcode.extra;
      res_nxt.dist_extra_width = dcode.width;
      res_nxt.total_bits       = 5'(res_nxt.sym_width) + {2'd0, lcode.width}
                               + 5'(dfhe_pkg::DIST_CODE_WIDTH) + {1'b0, dcode.width};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = res_vld_r;
  assign out_data  = res_r;

endmodule

`default_nettype wire

>>> hw/rtl/dfhe_checker.sv
// port-level checks of the token encoder, bound to the top level
`default_nettype none

module dfhe_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire dfhe_pkg::out_t out_data
);

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a bad token carries no code width, no distance and a zero bit count
  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_token |->
      out_data.total_bits == 5'd0 && out_data.sym_width == 4'd0
      && !out_data.has_distance)
    else $error("bad token with non-zero fields");

  // a literal result counts only its code
  a_literal_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.bad_token && !out_data.has_distance |->
      out_data.total_bits == 5'(out_data.sym_width)
      && out_data.len_extra_width == 3'd0)
    else $error("literal total bit count wrong");

  // an offered match result sums all its widths
  a_match_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.has_distance |->
      out_data.total_bits == 5'(out_data.sym_width) + {2'd0, out_data.len_extra_width}
        + 5'(dfhe_pkg::DIST_CODE_WIDTH) + {1'b0, out_data.dist_extra_width})
    else $error("match total bit count wrong");

endmodule

bind deflate_fixed_huffman_symbol_encoder dfhe_checker u_dfhe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
